// ----- rtl/core/pwm_dsl_pkg.sv -----
// Package for the PWM duty slew limiter: widths, reset values, codes,
// the configuration record and the duty clamp helper.
// No dependencies; every other file of the block imports it.
package pwm_dsl_pkg;

  localparam int CHANNELS     = 8;
  localparam int OUT_CHANNELS = 8;
  localparam int DUTY_W       = 14;
  localparam int REQ_W        = 15;
  localparam int FUNC_W       = 2;
  localparam int CHAN_W       = 4;
  localparam int MASK_W       = 8;
  localparam int COUNT_W      = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 14;

  localparam logic [DUTY_W-1:0] UNLIMITED_STEP = DUTY_W'(10000);
  localparam logic [DUTY_W-1:0] DUTY_RESET     = DUTY_W'(750);

  localparam logic [DUTY_W-1:0] STEP_LIMIT_RESET = DUTY_W'(20);
  localparam logic [DUTY_W-1:0] MIN_DUTY_RESET   = DUTY_W'(500);
  localparam logic [DUTY_W-1:0] MID_DUTY_RESET   = DUTY_W'(750);
  localparam logic [DUTY_W-1:0] MAX_DUTY_RESET   = DUTY_W'(1000);
  localparam logic [MASK_W-1:0] GROUP_A_RESET    = MASK_W'(8'h0F);
  localparam logic [MASK_W-1:0] GROUP_B_RESET    = MASK_W'(8'hF0);

  typedef logic [DUTY_W-1:0] duty_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_SET_TARGET = 2'd0,
    FUNC_ALL_MID    = 2'd1,
    FUNC_STEP       = 2'd2
  } func_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_LIMIT    = 3'd0,
    REG_MIN_DUTY      = 3'd1,
    REG_MID_DUTY      = 3'd2,
    REG_MAX_DUTY      = 3'd3,
    REG_REVERSE_GUARD = 3'd4,
    REG_ALL_CHANNELS  = 3'd5,
    REG_GROUP_A_MASK  = 3'd6,
    REG_GROUP_B_MASK  = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    duty_t             step_limit;
    duty_t             min_duty;
    duty_t             mid_duty;
    duty_t             max_duty;
    logic              reverse_guard;
    logic              all_channels;
    logic [MASK_W-1:0] group_a_mask;
    logic [MASK_W-1:0] group_b_mask;
  } cfg_t;

  // Lower limit first, then upper, so the upper limit wins when they cross.
  function automatic duty_t clamp_duty(duty_t v, duty_t lo, duty_t hi);
    duty_t r;
    r = (v < lo) ? lo : v;
    r = (r > hi) ? hi : r;
    return r;
  endfunction

endpackage

// ----- rtl/core/pwm_dsl_cmd_if.sv -----
// Command channel of the PWM duty slew limiter: valid/ready and one item.
// Depends on pwm_dsl_pkg.
interface pwm_dsl_cmd_if import pwm_dsl_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [FUNC_W-1:0]       func;
  logic [CHAN_W-1:0]       channel;
  logic signed [REQ_W-1:0] target_duty;

  modport source (output valid, func, channel, target_duty, input ready);
  modport sink   (input valid, func, channel, target_duty, output ready);
endinterface

// ----- rtl/core/pwm_dsl_res_if.sv -----
// Result channel of the PWM duty slew limiter: valid/ready and one frame.
// Depends on pwm_dsl_pkg.
interface pwm_dsl_res_if import pwm_dsl_pkg::*;;
  logic               valid;
  logic               ready;
  logic               status;
  logic               frame_valid;
  duty_t              duty_ch1;
  duty_t              duty_ch2;
  duty_t              duty_ch3;
  duty_t              duty_ch4;
  duty_t              duty_ch5;
  duty_t              duty_ch6;
  duty_t              duty_ch7;
  duty_t              duty_ch8;
  logic [COUNT_W-1:0] steps_done;

  modport source (output valid, status, frame_valid, duty_ch1, duty_ch2, duty_ch3,
                  duty_ch4, duty_ch5, duty_ch6, duty_ch7, duty_ch8, steps_done,
                  input ready);
  modport sink   (input valid, status, frame_valid, duty_ch1, duty_ch2, duty_ch3,
                  duty_ch4, duty_ch5, duty_ch6, duty_ch7, duty_ch8, steps_done,
                  output ready);
endinterface

// ----- rtl/core/pwm_dsl_cfg.sv -----
// Configuration register file of the PWM duty slew limiter.
// Depends on pwm_dsl_pkg.
module pwm_dsl_cfg import pwm_dsl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.step_limit    <= STEP_LIMIT_RESET;
      cfg.min_duty      <= MIN_DUTY_RESET;
      cfg.mid_duty      <= MID_DUTY_RESET;
      cfg.max_duty      <= MAX_DUTY_RESET;
      cfg.reverse_guard <= 1'b1;
      cfg.all_channels  <= 1'b0;
      cfg.group_a_mask  <= GROUP_A_RESET;
      cfg.group_b_mask  <= GROUP_B_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STEP_LIMIT:    cfg.step_limit    <= cfg_data[DUTY_W-1:0];
        REG_MIN_DUTY:      cfg.min_duty      <= cfg_data[DUTY_W-1:0];
        REG_MID_DUTY:      cfg.mid_duty      <= cfg_data[DUTY_W-1:0];
        REG_MAX_DUTY:      cfg.max_duty      <= cfg_data[DUTY_W-1:0];
        REG_REVERSE_GUARD: cfg.reverse_guard <= cfg_data[0];
        REG_ALL_CHANNELS:  cfg.all_channels  <= cfg_data[0];
        REG_GROUP_A_MASK:  cfg.group_a_mask  <= cfg_data[MASK_W-1:0];
        REG_GROUP_B_MASK:  cfg.group_b_mask  <= cfg_data[MASK_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/core/pwm_dsl_slew.sv -----
// Per-channel slew step of the PWM duty slew limiter: aim, limited move, clamp.
// Depends on pwm_dsl_pkg.
module pwm_dsl_slew import pwm_dsl_pkg::*; (
  input  cfg_t  cfg,
  input  duty_t step,
  input  duty_t cur,
  input  duty_t tgt,
  output duty_t nxt
);

  logic  crossing;
  duty_t aim;
  duty_t diff;
  duty_t moved;

  always_comb begin
    // Current and target strictly on opposite sides of mid: go to mid first.
    crossing = ((cur > cfg.mid_duty) && (tgt < cfg.mid_duty)) ||
               ((cur < cfg.mid_duty) && (tgt > cfg.mid_duty));
    aim = (cfg.reverse_guard && crossing) ? cfg.mid_duty : tgt;
    if (aim >= cur) begin
      diff  = aim - cur;
      moved = (diff > step) ? duty_t'(cur + step) : aim;
    end else begin
      diff  = cur - aim;
      moved = (diff > step) ? duty_t'(cur - step) : aim;
    end
    nxt = clamp_duty(moved, cfg.min_duty, cfg.max_duty);
  end

endmodule

// ----- rtl/core/pwm_duty_slew_limiter.sv -----
// Top level of the eight-channel PWM duty slew limiter.
// Depends on pwm_dsl_pkg, pwm_dsl_cmd_if, pwm_dsl_res_if, pwm_dsl_cfg and pwm_dsl_slew.

// The block takes one command beat per clock cycle and returns exactly one result beat
// for each. A beat is captured in an input register; from there one pass of short
// logic (a compare, a subtract and a clamp per channel, all channels side by side)
// updates the target and duty registers and loads the result register, so the
// sustained rate is one beat per cycle while results are taken as they come. A
// result that is not taken holds the pipeline, and the command channel stalls only
// when both the input register and the result register are full. Duty outputs always
// show the duties after the command of the beat on offer; steps_done counts step
// ticks and wraps. Configuration must be written only while no command is in flight.
module pwm_duty_slew_limiter import pwm_dsl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  pwm_dsl_cmd_if.sink           cmd,
  pwm_dsl_res_if.source         res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg;

  // Input register.
  logic                    s0_valid;
  logic [FUNC_W-1:0]       s0_func;
  logic [CHAN_W-1:0]       s0_channel;
  logic signed [REQ_W-1:0] s0_target;

  // Result register.
  logic res_valid;
  logic res_status;
  logic res_frame;

  // Block state.
  logic [CHANNELS-1:0][DUTY_W-1:0] cur_duty;
  logic [CHANNELS-1:0][DUTY_W-1:0] tgt_duty;
  logic                            group_toggle;
  logic [COUNT_W-1:0]              step_counter;

  logic                            advance;
  logic                            cmd_take;
  logic                            is_set;
  logic                            is_mid;
  logic                            is_step;
  logic [CHANNELS-1:0]             chan_sel;
  logic                            chan_bad;
  duty_t                           set_value;
  duty_t                           step_eff;
  logic [MASK_W-1:0]               step_mask;
  logic [CHANNELS-1:0][DUTY_W-1:0] slew_duty;
  duty_t                           out_duty [OUT_CHANNELS];

  pwm_dsl_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The input register moves on whenever the result register is empty or being taken.
  assign advance   = s0_valid && (!res_valid || res.ready);
  assign cmd.ready = !s0_valid || advance;
  assign cmd_take  = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (cmd.ready) begin
      s0_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      s0_func    <= cmd.func;
      s0_channel <= cmd.channel;
      s0_target  <= cmd.target_duty;
    end
  end

  // Command decode. The unused function code falls through and changes nothing.
  always_comb begin
    is_set  = 1'b0;
    is_mid  = 1'b0;
    is_step = 1'b0;
    unique case (func_t'(s0_func))
      FUNC_SET_TARGET: is_set  = 1'b1;
      FUNC_ALL_MID:    is_mid  = 1'b1;
      FUNC_STEP:       is_step = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      chan_sel[i] = (s0_channel == CHAN_W'(i + 1));
    end
  end

  // Channel numbers are 1-based; zero and anything past the last channel are refused.
  assign chan_bad  = is_set && (chan_sel == '0);
  // A negative request stands for mid.
  assign set_value = clamp_duty(s0_target[REQ_W-1] ? cfg.mid_duty : s0_target[DUTY_W-1:0],
                                cfg.min_duty, cfg.max_duty);
  // A step size of zero means no limit within the duty range.
  assign step_eff  = (cfg.step_limit == '0) ? UNLIMITED_STEP : cfg.step_limit;
  assign step_mask = cfg.all_channels ? {MASK_W{1'b1}} :
                     group_toggle     ? cfg.group_b_mask : cfg.group_a_mask;

  for (genvar g = 0; g < CHANNELS; g++) begin : g_chan
    pwm_dsl_slew u_slew (
      .cfg  (cfg),
      .step (step_eff),
      .cur  (cur_duty[g]),
      .tgt  (tgt_duty[g]),
      .nxt  (slew_duty[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cur_duty[i] <= DUTY_RESET;
        tgt_duty[i] <= DUTY_RESET;
      end
      group_toggle <= 1'b0;
      step_counter <= '0;
    end else if (advance) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (is_set && chan_sel[i]) begin
          tgt_duty[i] <= set_value;
        end else if (is_mid) begin
          tgt_duty[i] <= cfg.mid_duty;
        end
        if (is_step && step_mask[i]) begin
          cur_duty[i] <= slew_duty[i];
        end
      end
      if (is_step) begin
        step_counter <= step_counter + 1'b1;
        if (!cfg.all_channels) begin
          group_toggle <= !group_toggle;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_status <= chan_bad;
      res_frame  <= is_step;
    end
  end

  // The state only changes when a new beat enters the result register, so while a
  // beat waits the duty and counter registers already hold its values.
  always_comb begin
    for (int i = 0; i < OUT_CHANNELS; i++) begin
      out_duty[i] = (i < CHANNELS) ? cur_duty[i] : '0;
    end
  end

  assign res.valid       = res_valid;
  assign res.status      = res_status;
  assign res.frame_valid = res_frame;
  assign res.duty_ch1    = out_duty[0];
  assign res.duty_ch2    = out_duty[1];
  assign res.duty_ch3    = out_duty[2];
  assign res.duty_ch4    = out_duty[3];
  assign res.duty_ch5    = out_duty[4];
  assign res.duty_ch6    = out_duty[5];
  assign res.duty_ch7    = out_duty[6];
  assign res.duty_ch8    = out_duty[7];
  assign res.steps_done  = step_counter;

`ifndef NO_ASSERTIONS
  a_step_counts : assert property (@(posedge clk) disable iff (rst)
    (advance && is_step) |=> (step_counter == $past(step_counter) + 1'b1))
    else $error("step counter did not advance on a step tick");

  a_no_step_hold : assert property (@(posedge clk) disable iff (rst)
    !(advance && is_step) |=> $stable(step_counter) && $stable(cur_duty))
    else $error("duties or counter changed without a step tick");

  a_status_frame : assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res_status && res_frame))
    else $error("invalid-channel status reported on a step frame");

  a_stall_hold : assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res.ready) |=> $stable(tgt_duty) && $stable(group_toggle))
    else $error("state changed while a result beat was waiting");
`endif

endmodule

// ----- tb/pwm_duty_slew_limiter_tb.sv -----
// Self-checking testbench for the eight-channel PWM duty slew limiter.
// Depends on pwm_dsl_pkg, pwm_dsl_cmd_if, pwm_dsl_res_if and the
// pwm_duty_slew_limiter top level, which brings in pwm_dsl_cfg and pwm_dsl_slew.
module pwm_duty_slew_limiter_tb;
  import pwm_dsl_pkg::*;

  // The function code left unused by the block; it must change nothing.
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  // Generous bound on the whole run. The slowest correct run is roughly
  // 700 beats, some waiting out long sender gaps or long receiver stalls,
  // plus the drains around every register load.
  localparam int CYCLE_LIMIT = 400000;
  // Length of the receiver hold-off that forces the command channel to stall.
  localparam int HOLD_CYCLES = 60;
  // Cycles allowed after the last result before the block counts as idle.
  localparam int SETTLE_CYCLES = 4;

  // One expected result beat.
  typedef struct {
    logic               status;
    logic               frame_valid;
    duty_t              duty[CHANNELS];
    logic [COUNT_W-1:0] steps;
  } frame_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pwm_dsl_cmd_if cmd_ch ();
  pwm_dsl_res_if res_ch ();

  pwm_duty_slew_limiter u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .res       (res_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Our own copy of the slew limiter: configuration, duties, targets,
  // which group moves on the next alternating tick, and the step count.
  cfg_t               cfg_now;
  duty_t              duty_now[CHANNELS];
  duty_t              duty_target[CHANNELS];
  logic               next_group_b;
  logic [COUNT_W-1:0] steps_total;

  // Result beats still owed by the block, oldest first.
  frame_t expected_frames[$];

  // Idling knobs, in percent, set by the test in progress.
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  // The test raises hold_request; the receiver notices and serves it.
  int unsigned hold_request;
  int unsigned hold_served;
  int unsigned hold_left;

  int unsigned failures;
  int unsigned cycle_count;
  int unsigned beats_sent;
  int unsigned beats_checked;
  int unsigned ticks_sent;
  int unsigned config_loads;

  // Clock with a period of 12 time units.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Run-away guard: a hung handshake ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Clamp of the block: the lower limit is applied first and the upper one
  // second, so when the two limits cross the upper one wins.
  function automatic int limit_duty(int v);
    int r;
    r = v;
    if (r < int'(cfg_now.min_duty)) r = int'(cfg_now.min_duty);
    if (r > int'(cfg_now.max_duty)) r = int'(cfg_now.max_duty);
    return r;
  endfunction

  // Advances our copy of the block by one accepted command beat and returns
  // the result beat that the block must produce for it.
  function automatic frame_t apply_command(logic [FUNC_W-1:0] f, logic [CHAN_W-1:0] ch,
                                           logic signed [REQ_W-1:0] req);
    frame_t            fr;
    logic [MASK_W-1:0] mask;
    int                lim;
    int                mid;
    int                cur;
    int                tgt;
    int                aim;
    int                delta;
    int                v;
    fr.status      = 1'b0;
    fr.frame_valid = 1'b0;
    case (f)
      FUNC_SET_TARGET: begin
        if (ch < 1 || ch > CHANNELS) begin
          // Channel zero or beyond the last one: nothing is stored.
          fr.status = 1'b1;
        end else begin
          // A negative request stands for the neutral duty.
          v = (req < 0) ? int'(cfg_now.mid_duty) : int'(req);
          duty_target[ch - 1] = duty_t'(limit_duty(v));
        end
      end
      FUNC_ALL_MID: begin
        // Neutral duty is taken as written, with no clamp.
        for (int i = 0; i < CHANNELS; i++) duty_target[i] = cfg_now.mid_duty;
      end
      FUNC_STEP: begin
        if (cfg_now.all_channels) begin
          mask = '1;
        end else if (!next_group_b) begin
          next_group_b = 1'b1;
          mask = cfg_now.group_a_mask;
        end else begin
          next_group_b = 1'b0;
          mask = cfg_now.group_b_mask;
        end
        // A step size of zero means the move is effectively unbounded.
        lim = (cfg_now.step_limit == 0) ? int'(UNLIMITED_STEP) : int'(cfg_now.step_limit);
        mid = int'(cfg_now.mid_duty);
        for (int i = 0; i < CHANNELS; i++) begin
          if (mask[i]) begin
            cur = int'(duty_now[i]);
            tgt = int'(duty_target[i]);
            aim = tgt;
            // The guard stops a move straight across neutral: the channel
            // heads for neutral first and only then for its target.
            if (cfg_now.reverse_guard && ((cur > mid && tgt < mid) || (cur < mid && tgt > mid)))
              aim = mid;
            delta = aim - cur;
            if (delta > lim) delta = lim;
            if (delta < -lim) delta = -lim;
            duty_now[i] = duty_t'(limit_duty(cur + delta));
          end
        end
        steps_total    = steps_total + 1;
        fr.frame_valid = 1'b1;
      end
      default: begin
      end
    endcase
    for (int i = 0; i < CHANNELS; i++) fr.duty[i] = duty_now[i];
    fr.steps = steps_total;
    return fr;
  endfunction

  // Receiver: random stalls, plus a long hold-off whenever a test asks.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b1;
    end else if (hold_left > 0) begin
      res_ch.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_request != hold_served) begin
      hold_served = hold_request;
      hold_left   = HOLD_CYCLES - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic check_field(string name, logic [COUNT_W-1:0] exp, logic [COUNT_W-1:0] act);
    if (act !== exp) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp, act);
      failures++;
    end
  endtask

  // Checker: every result beat is compared with the oldest expectation.
  always @(posedge clk) begin
    frame_t exp;
    duty_t  got[CHANNELS];
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (expected_frames.size() == 0) begin
        $error("result beat arrived with no command outstanding");
        failures++;
      end else begin
        exp = expected_frames.pop_front();
        got[0] = res_ch.duty_ch1;
        got[1] = res_ch.duty_ch2;
        got[2] = res_ch.duty_ch3;
        got[3] = res_ch.duty_ch4;
        got[4] = res_ch.duty_ch5;
        got[5] = res_ch.duty_ch6;
        got[6] = res_ch.duty_ch7;
        got[7] = res_ch.duty_ch8;
        check_field("status", COUNT_W'(exp.status), COUNT_W'(res_ch.status));
        check_field("frame_valid", COUNT_W'(exp.frame_valid), COUNT_W'(res_ch.frame_valid));
        for (int i = 0; i < CHANNELS; i++)
          check_field($sformatf("duty_ch%0d", i + 1), COUNT_W'(exp.duty[i]),
                      COUNT_W'(got[i]));
        check_field("steps_done", exp.steps, res_ch.steps_done);
        beats_checked++;
      end
    end
  end

  // Offers one command beat, after a random gap, and returns at the clock
  // edge that accepts it. The next call may keep valid high without a dip.
  task automatic send_command(logic [FUNC_W-1:0] f, logic [CHAN_W-1:0] ch,
                              logic signed [REQ_W-1:0] req);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.func        <= f;
    cmd_ch.channel     <= ch;
    cmd_ch.target_duty <= req;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    expected_frames.push_back(apply_command(f, ch, req));
    beats_sent++;
    if (f == FUNC_STEP) ticks_sent++;
  endtask

  // Stops offering beats and waits until every owed result has come back,
  // then lets the settle time run out so that nothing is left in flight.
  task automatic wait_drained();
    cmd_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, int unsigned value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    @(posedge clk);
  endtask

  // Writes all eight registers back to back; only called with the block idle.
  task automatic load_config(int unsigned step, int unsigned lo, int unsigned mid,
                             int unsigned hi, bit guard, bit all_mode,
                             int unsigned mask_a, int unsigned mask_b);
    cfg_write(REG_STEP_LIMIT, step);
    cfg_write(REG_MIN_DUTY, lo);
    cfg_write(REG_MID_DUTY, mid);
    cfg_write(REG_MAX_DUTY, hi);
    cfg_write(REG_REVERSE_GUARD, guard);
    cfg_write(REG_ALL_CHANNELS, all_mode);
    cfg_write(REG_GROUP_A_MASK, mask_a);
    cfg_write(REG_GROUP_B_MASK, mask_b);
    cfg_we <= 1'b0;
    cfg_now.step_limit    = duty_t'(step);
    cfg_now.min_duty      = duty_t'(lo);
    cfg_now.mid_duty      = duty_t'(mid);
    cfg_now.max_duty      = duty_t'(hi);
    cfg_now.reverse_guard = guard;
    cfg_now.all_channels  = all_mode;
    cfg_now.group_a_mask  = MASK_W'(mask_a);
    cfg_now.group_b_mask  = MASK_W'(mask_b);
    config_loads++;
  endtask

  // Picks a fresh setting. Mostly sane limits with small steps, so that the
  // slew and the guard are exercised; now and then crossed limits, a neutral
  // duty outside the window, a step size of zero or one of the full range.
  task automatic random_config();
    int unsigned step;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    int unsigned pick;
    pick = $urandom_range(9);
    step = (pick == 0) ? 0 : (pick == 1) ? 10000 : (pick < 4) ? $urandom_range(10000)
         : $urandom_range(1, 300);
    lo   = $urandom_range(5000);
    hi   = $urandom_range(lo, 10000);
    mid  = $urandom_range(lo, hi);
    pick = $urandom_range(9);
    if (pick == 0) begin
      hi = $urandom_range(4000);
      lo = $urandom_range(hi + 1, 10000);
    end else if (pick == 1) begin
      mid = $urandom_range(10000);
    end
    load_config(step, lo, mid, hi, 1'($urandom_range(1)), 1'($urandom_range(1)),
                $urandom_range(255), $urandom_range(255));
  endtask

  // One random command beat. Most beats are well-formed target writes and
  // step ticks, since that is what moves the duties; the rest are invalid
  // channels, neutral resets and the unused function code. The fields that
  // a function ignores carry random values all the same.
  task automatic random_command();
    int unsigned             pick;
    logic [FUNC_W-1:0]       f;
    logic [CHAN_W-1:0]       ch;
    logic signed [REQ_W-1:0] req;
    pick = $urandom_range(99);
    ch   = CHAN_W'($urandom);
    case ($urandom_range(3))
      0:       req = REQ_W'(-int'($urandom_range(1, 10000)));
      1:       req = REQ_W'($urandom);
      default: req = REQ_W'($urandom_range(10000));
    endcase
    if (pick < 40) begin
      f  = FUNC_SET_TARGET;
      ch = CHAN_W'($urandom_range(1, CHANNELS));
    end else if (pick < 47) begin
      f  = FUNC_SET_TARGET;
      ch = ($urandom_range(3) == 0) ? '0 : CHAN_W'($urandom_range(CHANNELS + 1, 15));
    end else if (pick < 51) begin
      f = FUNC_ALL_MID;
    end else if (pick < 54) begin
      f = FUNC_UNUSED;
    end else begin
      f = FUNC_STEP;
    end
    send_command(f, ch, req);
  endtask

  // Reset settings: clamping at both limits, negative requests, invalid
  // channels, the unused code, full-width requests, group alternation.
  task automatic test_reset_setting();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_command(FUNC_SET_TARGET, 4'd1, 15'sd10000);
    send_command(FUNC_SET_TARGET, 4'd5, -15'sd1);
    send_command(FUNC_SET_TARGET, 4'd8, 15'sd0);
    send_command(FUNC_SET_TARGET, 4'd0, 15'sd600);
    send_command(FUNC_SET_TARGET, 4'd9, 15'sd600);
    send_command(FUNC_SET_TARGET, 4'd15, -15'sd10000);
    send_command(FUNC_UNUSED, 4'd3, 15'sd900);
    send_command(FUNC_STEP, 4'd0, 15'sd0);
    send_command(FUNC_STEP, 4'd0, 15'sd0);
    send_command(FUNC_SET_TARGET, 4'd2, 15'sd16383);
    send_command(FUNC_SET_TARGET, 4'd3, -15'sd16384);
    send_command(FUNC_STEP, 4'hF, -15'sd1);
    send_command(FUNC_ALL_MID, 4'd7, 15'sd5000);
    send_command(FUNC_STEP, 4'd0, 15'sd0);
    wait_drained();
  endtask

  // Extreme settings: an unbounded step across the full range with the
  // guard on, then crossed limits with the guard off and interleaved masks.
  task automatic test_extreme_settings();
    load_config(0, 0, 5000, 10000, 1'b1, 1'b1, 8'hFF, 8'h00);
    send_command(FUNC_SET_TARGET, 4'd1, 15'sd10000);
    send_command(FUNC_SET_TARGET, 4'd2, 15'sd0);
    send_command(FUNC_STEP, 4'd0, 15'sd0);
    send_command(FUNC_STEP, 4'd0, 15'sd0);
    send_command(FUNC_STEP, 4'd0, 15'sd0);
    wait_drained();
    load_config(10000, 8000, 10000, 2000, 1'b0, 1'b0, 8'hAA, 8'h55);
    send_command(FUNC_SET_TARGET, 4'd4, 15'sd5000);
    send_command(FUNC_ALL_MID, 4'd0, 15'sd0);
    send_command(FUNC_STEP, 4'd0, 15'sd0);
    send_command(FUNC_STEP, 4'd0, 15'sd0);
    wait_drained();
  endtask

  // A stretch of random beats under one idling pattern, with a fresh
  // setting loaded half way through.
  task automatic test_random_traffic(int unsigned idle, int unsigned stall, int unsigned n);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    random_config();
    for (int k = 0; k < n; k++) begin
      if (k == n / 2) begin
        wait_drained();
        random_config();
      end
      random_command();
    end
    wait_drained();
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so
  // the block fills up and stalls its command channel; the sender then
  // pauses until every owed result has come back.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    load_config(20, 500, 750, 1000, 1'b1, 1'b0, 8'h0F, 8'hF0);
    hold_request++;
    for (int k = 0; k < 24; k++) random_command();
    wait_drained();
  endtask

  initial begin
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_data           = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.func        = '0;
    cmd_ch.channel     = '0;
    cmd_ch.target_duty = '0;
    res_ch.ready       = 1'b1;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    hold_request       = 0;
    hold_served        = 0;
    hold_left          = 0;
    failures           = 0;
    cycle_count        = 0;
    beats_sent         = 0;
    beats_checked      = 0;
    ticks_sent         = 0;
    config_loads       = 0;

    // Our copy starts from the reset state of the block.
    cfg_now.step_limit    = STEP_LIMIT_RESET;
    cfg_now.min_duty      = MIN_DUTY_RESET;
    cfg_now.mid_duty      = MID_DUTY_RESET;
    cfg_now.max_duty      = MAX_DUTY_RESET;
    cfg_now.reverse_guard = 1'b1;
    cfg_now.all_channels  = 1'b0;
    cfg_now.group_a_mask  = GROUP_A_RESET;
    cfg_now.group_b_mask  = GROUP_B_RESET;
    for (int i = 0; i < CHANNELS; i++) begin
      duty_now[i]    = DUTY_RESET;
      duty_target[i] = DUTY_RESET;
    end
    next_group_b = 1'b0;
    steps_total  = '0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_setting();
    test_extreme_settings();
    test_random_traffic(0, 0, 160);
    test_random_traffic(88, 0, 160);
    test_random_traffic(0, 88, 160);
    test_random_traffic(16, 16, 160);
    test_backpressure();

    // Everything is drained; keep the clock running in case a stray beat
    // is still to come, then report.
    repeat (8) @(posedge clk);
    if (expected_frames.size() != 0) begin
      $error("%0d result beats never arrived", expected_frames.size());
      failures++;
    end
    $display("Sent %0d command beats (%0d step ticks) over %0d register loads;",
             beats_sent, ticks_sent, config_loads);
    $display("checked %0d result beats field by field, %0d mismatches.",
             beats_checked, failures);
    if (failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
